// File: rtl/core/gaussian_blur_3x3_core_defines.svh
// Assertion helpers for the blur core. Assertions are compiled out when SYNTH is set.
`ifndef GAUSSIAN_BLUR_3X3_CORE_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_CORE_DEFINES_SVH

`ifndef SYNTH
`define GB3_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define GB3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define GB3_ASSERT(lbl, prop)
`define GB3_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// File: rtl/core/gb3_pkg.sv
package gb3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 11;
    localparam int ROWS_W      = 13;
    localparam int MAX_ROWS    = 4096;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = PIX_W + 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
    localparam int CMP_W       = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_ROWS  = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eor;
        logic             eof;
    } out_item_t;

    typedef struct packed {
        logic [COL_W-1:0] idx;
        logic             emit_a;
        logic             emit_b;
        logic             pass;
        logic             eof;
    } s1_ctrl_t;

endpackage

// File: rtl/core/gaussian_blur_3x3_core.sv
// 3x3 binomial blur on a raster stream of 8-bit grey pixels. A frame is image_width
// pixels wide and inner_rows+2 rows high (halo row, inner rows, halo row); only the
// inner rows come out, with columns 0 and width-1 passed through and every other
// column replaced by the 1-2-1 / 2-4-2 / 1-2-1 weighted sum shifted right by 4.
// Rate: one pixel per clock sustained. Each accepted pixel reads the two previous
// rows at its column from a single 1024 x 16 line store (read at accept, written
// back the following cycle), so the line store port sets the one-item-per-clock
// figure. Results are formed in the filter stage and pass through an 8-entry output
// queue; in_stall rises only when that queue cannot take the two results an item
// may cause, i.e. under output back-pressure. The last pixel of a row gives two
// results. Write image_width and inner_rows only while idle.
`include "gaussian_blur_3x3_core_defines.svh"

module gaussian_blur_3x3_core
    import gb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  end_of_row,
    output logic                  end_of_frame
);

    // ---------------- configuration ----------------
    logic [WIDTH_W-1:0] image_width_reg;
    logic [ROWS_W-1:0]  inner_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_W'(MAX_WIDTH);
            inner_rows_reg  <= ROWS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_INNER_ROWS:  inner_rows_reg  <= cfg_data[ROWS_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamp into the supported range
    logic [WIDTH_W-1:0] width_eff;
    logic [WIDTH_W-1:0] width_last;
    logic [ROWS_W-1:0]  rows_eff;
    logic [ROWS_W-1:0]  last_row;

    always_comb
    begin
        if (image_width_reg < WIDTH_W'(3))
            width_eff = WIDTH_W'(3);
        else if (image_width_reg > WIDTH_W'(MAX_WIDTH))
            width_eff = WIDTH_W'(MAX_WIDTH);
        else
            width_eff = image_width_reg;
        width_last = width_eff - WIDTH_W'(1);
        rows_eff   = (inner_rows_reg > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : inner_rows_reg;
        last_row   = rows_eff + ROWS_W'(1);
    end

    // ---------------- input stage: position counters, line store read ----------------
    logic                 in_acc;
    logic [COL_W-1:0]     col_count_reg,  col_count_next;
    logic [ROWS_W-1:0]    row_count_reg,  row_count_next;
    logic [CMP_W-1:0]     col_ext;
    logic                 eor;
    logic                 row_out;
    s1_ctrl_t             s1_ctrl_next;

    assign in_acc  = in_valid && !in_stall;
    assign col_ext = CMP_W'(col_count_reg);
    assign eor     = col_ext >= CMP_W'(width_last);
    assign row_out = row_count_reg >= ROWS_W'(2);

    always_comb
    begin
        s1_ctrl_next.idx    = col_count_reg;
        s1_ctrl_next.emit_a = row_out && (col_count_reg != '0);
        s1_ctrl_next.emit_b = row_out && eor;
        // previous column is a border column: col-1 == 0 or col-1 >= width-1
        s1_ctrl_next.pass   = (col_count_reg == COL_W'(1)) || (col_ext >= CMP_W'(width_eff));
        s1_ctrl_next.eof    = eor && (row_count_reg >= last_row);

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_acc)
        begin
            if (eor)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg >= last_row) ? '0
                                                             : row_count_reg + ROWS_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // line store: [15:8] = two rows back, [7:0] = previous row
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_rd_reg;
    logic               s1_valid_reg;
    s1_ctrl_t           s1_ctrl_reg;
    logic [PIX_W-1:0]   s1_bot_reg;

    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;

    assign top = line_rd_reg[2*PIX_W-1:PIX_W];
    assign mid = line_rd_reg[PIX_W-1:0];

    // read at accept, write back in the following cycle; consecutive items never share a column
    always_ff @(posedge clk)
    begin
        if (in_acc)
            line_rd_reg <= line_mem[col_count_reg];
        if (s1_valid_reg)
            line_mem[s1_ctrl_reg.idx] <= {mid, s1_bot_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_acc;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_bot_reg  <= pixel_in;
        end
    end

    // ---------------- filter stage ----------------
    // win: 0..2 = top/mid/bot two columns back, 3..5 = previous column
    logic [PIX_W-1:0] win_reg [6];
    logic [SUM_W-1:0] sum;
    out_item_t        item_a;
    out_item_t        item_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_bot_reg;
        end
    end

    always_comb
    begin
        sum = SUM_W'(win_reg[0])         + (SUM_W'(win_reg[1]) << 1) + SUM_W'(win_reg[2])
            + (SUM_W'(win_reg[3]) << 1)  + (SUM_W'(win_reg[4]) << 2) + (SUM_W'(win_reg[5]) << 1)
            + SUM_W'(top)                + (SUM_W'(mid) << 1)        + SUM_W'(s1_bot_reg);

        item_a.pixel = s1_ctrl_reg.pass ? win_reg[4] : sum[SUM_W-1:4];
        item_a.eor   = 1'b0;
        item_a.eof   = 1'b0;

        item_b.pixel = mid;
        item_b.eor   = 1'b1;
        item_b.eof   = s1_ctrl_reg.eof;
    end

    // ---------------- output queue ----------------
    out_item_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [1:0]            n_push;
    logic                  pop;
    out_item_t             push0;

    always_comb
    begin
        n_push = '0;
        if (s1_valid_reg)
            n_push = 2'(s1_ctrl_reg.emit_a) + 2'(s1_ctrl_reg.emit_b);
        push0 = s1_ctrl_reg.emit_a ? item_a : item_b;
    end

    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && !out_stall;
    assign pixel_out    = fifo_mem[head_reg].pixel;
    assign end_of_row   = fifo_mem[head_reg].eor;
    assign end_of_frame = fifo_mem[head_reg].eof;

    // room for two more results beyond what the filter stage is about to push
    assign in_stall = (count_reg + (s1_valid_reg ? FIFO_CNT_W'(2) : FIFO_CNT_W'(0)))
                      > FIFO_CNT_W'(FIFO_DEPTH - 2);

    always_comb
    begin
        head_next  = pop ? head_reg + FIFO_PTR_W'(1) : head_reg;
        tail_next  = tail_reg + FIFO_PTR_W'(n_push);
        count_next = count_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            fifo_mem[tail_reg] <= push0;
        if (n_push == 2'd2)
            fifo_mem[tail_reg + FIFO_PTR_W'(1)] <= item_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // ---------------- checks ----------------
    `GB3_ASSERT_IMP(a_no_line_overlap, s1_valid_reg && in_acc, s1_ctrl_reg.idx != col_count_reg)
    `GB3_ASSERT(a_queue_room, (32'(count_reg) + 32'(n_push)) <= FIFO_DEPTH)
    `GB3_ASSERT_IMP(a_eof_on_row_end, out_valid && end_of_frame, end_of_row)

endmodule
